// ===== hdl/pulse_count_voice_track_sequencer_macros.svh =====
// assertion macros shared by the sequencer modules
`ifndef PULSE_COUNT_VOICE_TRACK_SEQUENCER_MACROS_SVH
`define PULSE_COUNT_VOICE_TRACK_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define PCVTS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequence holds in the cycle after the trigger
`define PCVTS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define PCVTS_ASSERT_ALWAYS(label, cond, msg)
`define PCVTS_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

// ===== hdl/pcvts_pkg.sv =====
package pcvts_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QUEUED_W    = 5;

    // word field widths
    localparam int KIND_W  = 2;
    localparam int TRACK_W = 8;
    localparam int PHASE_W = 2;

    // request codes
    localparam logic [KIND_W-1:0] KIND_PLAY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // tick counter and pulse timing
    localparam int                 COUNT_W         = 9;
    localparam int                 LIMIT_W         = COUNT_W + 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 9'd511;
    localparam logic [COUNT_W-1:0] SEL_RST_END     = 9'd2;
    localparam logic [COUNT_W-1:0] SEL_TRAIN_START = 9'd4;
    localparam logic [LIMIT_W-1:0] SEL_LIMIT_OFS   = 10'd6;
    localparam logic [COUNT_W-1:0] STOP_RST_START  = 9'd1;
    localparam logic [COUNT_W-1:0] STOP_RST_END    = 9'd3;
    localparam logic [COUNT_W-1:0] STOP_LEN        = 9'd4;
    localparam logic [COUNT_W-1:0] STOP_KEEP_BELOW = 9'd4;

    // queue controls from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctl_t;

    // one status word
    typedef struct packed {
        logic                reset_line;
        logic                data_line;
        logic [PHASE_W-1:0]  phase;
        logic [TRACK_W-1:0]  track_now;
        logic [QUEUED_W-1:0] queued;
        logic                ticking;
    } status_t;

endpackage

// ===== hdl/pcvts_if.sv =====
// request channel
interface pcvts_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [pcvts_pkg::KIND_W-1:0]     kind;
    logic [pcvts_pkg::TRACK_W-1:0]    track_id;
    logic                             busy_level;

    modport source (output valid, kind, track_id, busy_level, input ready);
    modport sink   (input valid, kind, track_id, busy_level, output ready);
endinterface

// status channel
interface pcvts_status_if;
    logic                             valid;
    logic                             ready;
    logic                             reset_line;
    logic                             data_line;
    logic [pcvts_pkg::PHASE_W-1:0]    phase;
    logic [pcvts_pkg::TRACK_W-1:0]    track_now;
    logic [pcvts_pkg::QUEUED_W-1:0]   queued;
    logic                             ticking;

    modport source (output valid, reset_line, data_line, phase, track_now, queued, ticking,
                    input ready);
    modport sink   (input valid, reset_line, data_line, phase, track_now, queued, ticking,
                    output ready);
endinterface

// ===== hdl/pcvts_cell.sv =====
// one queue slot: takes its neighbor's entry on a shift, or a new entry on a load
module pcvts_cell (
    input  logic                          clk,
    input  logic                          shift,
    input  logic                          load,
    input  logic [pcvts_pkg::TRACK_W-1:0] nbr_data,
    input  logic [pcvts_pkg::TRACK_W-1:0] new_data,
    output logic [pcvts_pkg::TRACK_W-1:0] data
);

    logic [pcvts_pkg::TRACK_W-1:0] data_reg;

    // slot storage
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= nbr_data;
        end
        else if (load)
        begin
            data_reg <= new_data;
        end
    end

    assign data = data_reg;

endmodule

// ===== hdl/pcvts_queue.sv =====
`include "pulse_count_voice_track_sequencer_macros.svh"

// track fifo as a row of cells, head in cell 0, pop shifts the row toward the head
module pcvts_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcvts_pkg::queue_ctl_t         ctl,
    input  logic [pcvts_pkg::TRACK_W-1:0] push_data,
    output logic [pcvts_pkg::TRACK_W-1:0] head,
    output logic [pcvts_pkg::FILL_W-1:0]  fill_next
);

    logic [pcvts_pkg::FILL_W-1:0]  fill_reg;
    logic                          push_ok;
    logic [pcvts_pkg::TRACK_W-1:0] link [pcvts_pkg::QUEUE_DEPTH];
    logic [pcvts_pkg::TRACK_W-1:0] nbr  [pcvts_pkg::QUEUE_DEPTH];

    // track zero and a full queue are dropped
    assign push_ok = ctl.push && !ctl.clear && (push_data != '0)
                     && (fill_reg < pcvts_pkg::FILL_W'(pcvts_pkg::QUEUE_DEPTH));

    // the chain of slots
    for (genvar i = 0; i < pcvts_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == pcvts_pkg::QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr[i] = link[i];
        end
        else
        begin : g_mid
            assign nbr[i] = link[i + 1];
        end

        pcvts_cell u_cell (
            .clk      (clk),
            .shift    (ctl.pop),
            .load     (push_ok && (fill_reg == pcvts_pkg::FILL_W'(i))),
            .nbr_data (nbr[i]),
            .new_data (push_data),
            .data     (link[i])
        );
    end

    assign head = link[0];

    // fill count
    always_comb
    begin
        priority if (ctl.clear)
        begin
            fill_next = '0;
        end
        else if (push_ok)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctl.pop && (fill_reg != '0))
        begin
            fill_next = fill_reg - 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    `PCVTS_ASSERT_ALWAYS(a_fill_bound, fill_reg <= pcvts_pkg::FILL_W'(pcvts_pkg::QUEUE_DEPTH), "queue fill above depth")
    `PCVTS_ASSERT_NEXT(a_clear_empty, ctl.clear, fill_reg == '0, "queue not empty after clear")
    `PCVTS_ASSERT_NEXT(a_push_grows, push_ok, fill_reg == $past(fill_reg) + 1'b1, "push did not grow queue")

endmodule

// ===== hdl/pulse_count_voice_track_sequencer.sv =====
// channel   role   word
// cmd       sink   kind, track_id, busy_level
// status    source reset_line, data_line, phase, track_now, queued, ticking
//
// one word in, one status word out; a word is taken every cycle while the skid slot is empty
// the state update of one word completes in the cycle it is accepted
// status words pass an output register plus one skid slot, so cmd stalls only
// when both are full; reset clears state, queue fill and both output slots
// queue pop shifts the whole cell row toward the head in the same cycle
`include "pulse_count_voice_track_sequencer_macros.svh"

module pulse_count_voice_track_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    pcvts_cmd_if.sink             cmd,
    pcvts_status_if.source        status
);

    typedef enum logic [pcvts_pkg::PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_SELECT = 2'd1,
        PH_DONE   = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [pcvts_pkg::TRACK_W-1:0]  track_reg, track_next;
    logic [pcvts_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                           rst_pin_reg, rst_pin_next;
    logic                           data_pin_reg, data_pin_next;
    logic                           timer_reg, timer_next;

    logic                           accept;
    logic [pcvts_pkg::COUNT_W-1:0]  count_inc;
    logic [pcvts_pkg::LIMIT_W-1:0]  sel_limit;
    logic [pcvts_pkg::LIMIT_W-1:0]  sel_limit_cap;
    pcvts_pkg::queue_ctl_t          qctl;
    logic [pcvts_pkg::TRACK_W-1:0]  q_head;
    logic [pcvts_pkg::FILL_W-1:0]   q_fill_next;
    logic [pcvts_pkg::FILL_W-1:0]   q_fill_reg;
    pcvts_pkg::status_t             word_new;

    logic                           out_valid_reg;
    pcvts_pkg::status_t             out_word_reg;
    logic                           skid_valid_reg;
    pcvts_pkg::status_t             skid_word_reg;

    assign cmd.ready = !skid_valid_reg;
    assign accept    = cmd.valid && cmd.ready;

    // queue of waiting tracks
    pcvts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (qctl),
        .push_data (cmd.track_id),
        .head      (q_head),
        .fill_next (q_fill_next)
    );

    // saturating tick count and end of pulse train
    assign count_inc     = (count_reg < pcvts_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign sel_limit     = {1'b0, track_reg, 1'b0} + pcvts_pkg::SEL_LIMIT_OFS;
    assign sel_limit_cap = (sel_limit > pcvts_pkg::LIMIT_W'(pcvts_pkg::COUNT_MAX))
                           ? pcvts_pkg::LIMIT_W'(pcvts_pkg::COUNT_MAX) : sel_limit;

    // sequencer next state
    always_comb
    begin
        phase_next    = phase_reg;
        track_next    = track_reg;
        count_next    = count_reg;
        rst_pin_next  = rst_pin_reg;
        data_pin_next = data_pin_reg;
        timer_next    = timer_reg;
        qctl          = '0;

        if (accept)
        begin
            unique case (cmd.kind)
                pcvts_pkg::KIND_PLAY:
                begin
                    if ((phase_reg == PH_IDLE) && cmd.busy_level)
                    begin
                        phase_next = PH_SELECT;
                        track_next = cmd.track_id;
                        count_next = '0;
                        timer_next = 1'b1;
                    end
                    else
                    begin
                        qctl.push = 1'b1;
                    end
                end
                pcvts_pkg::KIND_STOP:
                begin
                    if (!((phase_reg == PH_IDLE) && cmd.busy_level))
                    begin
                        qctl.clear = 1'b1;
                        if (count_reg >= pcvts_pkg::STOP_KEEP_BELOW)
                        begin
                            count_next = '0;
                        end
                        track_next = '0;
                        phase_next = PH_STOP;
                        timer_next = 1'b1;
                    end
                end
                pcvts_pkg::KIND_TICK:
                begin
                    if (timer_reg)
                    begin
                        priority if ((phase_reg == PH_DONE) && cmd.busy_level)
                        begin
                            if (q_fill_reg == '0)
                            begin
                                track_next = '0;
                                timer_next = 1'b0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                qctl.pop   = 1'b1;
                                phase_next = PH_SELECT;
                                track_next = q_head;
                                count_next = '0;
                            end
                        end
                        else if (phase_reg == PH_SELECT)
                        begin
                            // reset pulse, then data toggles
                            priority if (count_reg == '0)
                            begin
                                rst_pin_next  = 1'b1;
                                data_pin_next = 1'b0;
                            end
                            else if (count_reg == pcvts_pkg::SEL_RST_END)
                            begin
                                rst_pin_next = 1'b0;
                            end
                            else if (count_reg >= pcvts_pkg::SEL_TRAIN_START)
                            begin
                                data_pin_next = !data_pin_reg;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                            count_next = count_inc;
                            if ({1'b0, count_inc} >= sel_limit_cap)
                            begin
                                count_next    = '0;
                                rst_pin_next  = 1'b0;
                                data_pin_next = 1'b0;
                                phase_next    = PH_DONE;
                            end
                        end
                        else if (phase_reg == PH_STOP)
                        begin
                            // short reset pulse
                            priority if (count_reg == '0)
                            begin
                                data_pin_next = 1'b0;
                            end
                            else if (count_reg == pcvts_pkg::STOP_RST_START)
                            begin
                                rst_pin_next = 1'b1;
                            end
                            else if (count_reg == pcvts_pkg::STOP_RST_END)
                            begin
                                rst_pin_next = 1'b0;
                            end
                            else
                            begin
                                count_next = count_inc;
                            end
                            count_next = count_inc;
                            if (count_inc >= pcvts_pkg::STOP_LEN)
                            begin
                                count_next    = '0;
                                rst_pin_next  = 1'b0;
                                data_pin_next = 1'b0;
                                phase_next    = PH_DONE;
                            end
                        end
                        else
                        begin
                            phase_next = phase_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // state after this word
    always_comb
    begin
        word_new.reset_line = rst_pin_next;
        word_new.data_line  = data_pin_next;
        word_new.phase      = phase_next;
        word_new.track_now  = track_next;
        word_new.queued     = pcvts_pkg::QUEUED_W'(q_fill_next);
        word_new.ticking    = timer_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            track_reg    <= '0;
            count_reg    <= '0;
            rst_pin_reg  <= 1'b0;
            data_pin_reg <= 1'b0;
            timer_reg    <= 1'b0;
            q_fill_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            track_reg    <= track_next;
            count_reg    <= count_next;
            rst_pin_reg  <= rst_pin_next;
            data_pin_reg <= data_pin_next;
            timer_reg    <= timer_next;
            q_fill_reg   <= q_fill_next;
        end
    end

    // output register with skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || status.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || status.ready)
        begin
            if (skid_valid_reg)
            begin
                out_word_reg <= skid_word_reg;
            end
            else if (accept)
            begin
                out_word_reg <= word_new;
            end
        end
        else if (accept)
        begin
            skid_word_reg <= word_new;
        end
    end

    assign status.valid      = out_valid_reg;
    assign status.reset_line = out_word_reg.reset_line;
    assign status.data_line  = out_word_reg.data_line;
    assign status.phase      = out_word_reg.phase;
    assign status.track_now  = out_word_reg.track_now;
    assign status.queued     = out_word_reg.queued;
    assign status.ticking    = out_word_reg.ticking;

    `PCVTS_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid slot filled ahead of output")
    `PCVTS_ASSERT_ALWAYS(a_timer_phase, timer_reg == (phase_reg != PH_IDLE), "timer and idle phase disagree")
    `PCVTS_ASSERT_ALWAYS(a_reset_phase, !rst_pin_reg || (phase_reg == PH_SELECT) || (phase_reg == PH_STOP), "reset pin high outside a pulse phase")
    `PCVTS_ASSERT_NEXT(a_stall_to_skid, accept && out_valid_reg && !status.ready, skid_valid_reg, "stalled word not held in skid slot")

endmodule

// ===== tb/pulse_count_voice_track_sequencer_tb.sv =====
module pulse_count_voice_track_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // phase codes as shown on the status word
    localparam logic [pcvts_pkg::PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [pcvts_pkg::PHASE_W-1:0] PH_SELECT = 2'd1;
    localparam logic [pcvts_pkg::PHASE_W-1:0] PH_DONE   = 2'd2;
    localparam logic [pcvts_pkg::PHASE_W-1:0] PH_STOP   = 2'd3;

    // request code with no meaning, the block only reports its state
    localparam logic [pcvts_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int WORDS_PER_PASS = 160;

    typedef struct packed {
        logic [pcvts_pkg::KIND_W-1:0]  kind;
        logic [pcvts_pkg::TRACK_W-1:0] track_id;
        logic                          busy_level;
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n;

    pcvts_cmd_if    cmd_bus();
    pcvts_status_if status_bus();

    pulse_count_voice_track_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .status (status_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // words waiting to be driven and status words still owed by the block
    cmd_word_t           cmd_backlog[$];
    pcvts_pkg::status_t  status_owed[$];
    cmd_word_t           next_word;
    int                  words_queued;
    int                  mismatches = 0;
    int                  cycles = 0;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    // shadow of the sequencer state
    logic [pcvts_pkg::PHASE_W-1:0] seq_phase = PH_IDLE;
    logic [pcvts_pkg::TRACK_W-1:0] seq_track = '0;
    logic [pcvts_pkg::COUNT_W-1:0] seq_count = '0;
    logic                          seq_rst   = 1'b0;
    logic                          seq_data  = 1'b0;
    logic                          seq_timer = 1'b0;
    logic [pcvts_pkg::TRACK_W-1:0] track_fifo[$];

    function automatic void count_up();
        if (seq_count != pcvts_pkg::COUNT_MAX)
            seq_count = seq_count + 1'b1;
    endfunction

    // pulse train: reset pulse, then one data toggle per tick up to the limit
    function automatic void select_tick();
        logic [pcvts_pkg::LIMIT_W-1:0] sel_limit;
        if (seq_count == '0)
        begin
            seq_rst  = 1'b1;
            seq_data = 1'b0;
        end
        else if (seq_count == pcvts_pkg::SEL_RST_END)
            seq_rst = 1'b0;
        else if (seq_count >= pcvts_pkg::SEL_TRAIN_START)
            seq_data = ~seq_data;
        count_up();
        sel_limit = {1'b0, seq_track, 1'b0} + pcvts_pkg::SEL_LIMIT_OFS;
        if (sel_limit > {1'b0, pcvts_pkg::COUNT_MAX})
            sel_limit = {1'b0, pcvts_pkg::COUNT_MAX};
        if ({1'b0, seq_count} >= sel_limit)
        begin
            seq_count = '0;
            seq_rst   = 1'b0;
            seq_data  = 1'b0;
            seq_phase = PH_DONE;
        end
    endfunction

    // short reset pulse that stops the chip
    function automatic void stop_tick();
        if (seq_count == '0)
            seq_data = 1'b0;
        else if (seq_count == pcvts_pkg::STOP_RST_START)
            seq_rst = 1'b1;
        else if (seq_count == pcvts_pkg::STOP_RST_END)
            seq_rst = 1'b0;
        count_up();
        if (seq_count >= pcvts_pkg::STOP_LEN)
        begin
            seq_count = '0;
            seq_rst   = 1'b0;
            seq_data  = 1'b0;
            seq_phase = PH_DONE;
        end
    endfunction

    // apply one accepted word and record the status word it must produce
    function automatic void advance_sequencer(cmd_word_t w);
        pcvts_pkg::status_t s;
        case (w.kind)
            pcvts_pkg::KIND_PLAY:
            begin
                if (seq_phase == PH_IDLE && w.busy_level)
                begin
                    seq_phase = PH_SELECT;
                    seq_track = w.track_id;
                    seq_count = '0;
                    seq_timer = 1'b1;
                end
                else if (w.track_id != '0 && track_fifo.size() < pcvts_pkg::QUEUE_DEPTH)
                    track_fifo.push_back(w.track_id);
            end
            pcvts_pkg::KIND_STOP:
            begin
                if (!(seq_phase == PH_IDLE && w.busy_level))
                begin
                    track_fifo.delete();
                    // a count below the keep threshold survives the stop
                    if (seq_count >= pcvts_pkg::STOP_KEEP_BELOW)
                        seq_count = '0;
                    seq_track = '0;
                    seq_phase = PH_STOP;
                    seq_timer = 1'b1;
                end
            end
            pcvts_pkg::KIND_TICK:
            begin
                if (seq_timer)
                begin
                    if (seq_phase == PH_DONE && w.busy_level)
                    begin
                        if (track_fifo.size() == 0)
                        begin
                            seq_track = '0;
                            seq_timer = 1'b0;
                            seq_phase = PH_IDLE;
                        end
                        else
                        begin
                            seq_phase = PH_SELECT;
                            seq_track = track_fifo.pop_front();
                            seq_count = '0;
                        end
                    end
                    else if (seq_phase == PH_SELECT)
                        select_tick();
                    else if (seq_phase == PH_STOP)
                        stop_tick();
                end
            end
            default:
            begin
            end
        endcase
        s.reset_line = seq_rst;
        s.data_line  = seq_data;
        s.phase      = seq_phase;
        s.track_now  = seq_track;
        s.queued     = pcvts_pkg::QUEUED_W'(track_fifo.size());
        s.ticking    = seq_timer;
        status_owed.push_back(s);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // cmd driver, predicts each word as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid      <= 1'b0;
            cmd_bus.kind       <= pcvts_pkg::KIND_PLAY;
            cmd_bus.track_id   <= '0;
            cmd_bus.busy_level <= 1'b0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                advance_sequencer({cmd_bus.kind, cmd_bus.track_id, cmd_bus.busy_level});
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word           = cmd_backlog.pop_front();
                    cmd_bus.valid      <= 1'b1;
                    cmd_bus.kind       <= next_word.kind;
                    cmd_bus.track_id   <= next_word.track_id;
                    cmd_bus.busy_level <= next_word.busy_level;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // status monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_bus.ready <= 1'b0;
        else
        begin
            if (status_bus.valid && status_bus.ready)
            begin
                if (status_owed.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: status word with none expected, expected nothing, got %h",
                             $time, {status_bus.reset_line, status_bus.data_line,
                                     status_bus.phase, status_bus.track_now,
                                     status_bus.queued, status_bus.ticking});
                end
                else
                begin
                    check_field("reset_line", status_owed[0].reset_line, status_bus.reset_line);
                    check_field("data_line", status_owed[0].data_line, status_bus.data_line);
                    check_field("phase", status_owed[0].phase, status_bus.phase);
                    check_field("track_now", status_owed[0].track_now, status_bus.track_now);
                    check_field("queued", status_owed[0].queued, status_bus.queued);
                    check_field("ticking", status_owed[0].ticking, status_bus.ticking);
                    void'(status_owed.pop_front());
                end
            end
            status_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("pulse_count_voice_track_sequencer_tb: done, errors");
            $finish;
        end
    end

    task automatic enqueue_word(logic [pcvts_pkg::KIND_W-1:0] kind,
                                logic [pcvts_pkg::TRACK_W-1:0] id, logic busy);
        cmd_word_t w;
        w.kind       = kind;
        w.track_id   = id;
        w.busy_level = busy;
        cmd_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic enqueue_ticks(int n, int busy_pct);
        repeat (n)
            enqueue_word(pcvts_pkg::KIND_TICK, 8'($urandom), $urandom_range(99) < busy_pct);
    endtask

    // stop, finish the stop pulse and release to idle
    task automatic go_idle();
        enqueue_word(pcvts_pkg::KIND_STOP, 8'($urandom), 1'b0);
        enqueue_ticks(4, 50);
        enqueue_word(pcvts_pkg::KIND_TICK, 8'($urandom), 1'b1);
    endtask

    // play one track; ids up to 12 tick through the whole pulse train, larger ids a random number of ticks
    task automatic play_and_select(logic [pcvts_pkg::TRACK_W-1:0] id);
        enqueue_word(pcvts_pkg::KIND_PLAY, id, 1'b1);
        if (id <= 12)
            enqueue_ticks((id + 1) * 2 + 4 + $urandom_range(0, 2), 50);
        else
            enqueue_ticks($urandom_range(1, 30), 50);
        if ($urandom_range(99) < 80)
            enqueue_word(pcvts_pkg::KIND_TICK, 8'($urandom), 1'b1);
    endtask

    task automatic random_episode();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            if ($urandom_range(1))
                go_idle();
            if ($urandom_range(99) < 85)
                play_and_select(8'($urandom_range(0, 7)));
            else
                play_and_select(8'($urandom));
        end
        else if (pick < 65)
        begin
            // pile up requests while a track is being selected
            enqueue_word(pcvts_pkg::KIND_PLAY, 8'($urandom_range(0, 5)), 1'b1);
            n = $urandom_range(1, 20);
            repeat (n)
            begin
                if ($urandom_range(99) < 75)
                    enqueue_word(pcvts_pkg::KIND_PLAY, 8'($urandom_range(0, 5)),
                                 $urandom_range(99) < 20);
                else
                    enqueue_word(pcvts_pkg::KIND_PLAY, 8'($urandom), 1'($urandom_range(1)));
            end
            enqueue_ticks($urandom_range(10, 60), 75);
        end
        else if (pick < 80)
        begin
            // stop at a random point of the work
            enqueue_ticks($urandom_range(0, 5), 50);
            enqueue_word(pcvts_pkg::KIND_STOP, 8'($urandom), 1'($urandom_range(1)));
            enqueue_ticks($urandom_range(1, 6), 50);
            enqueue_word(pcvts_pkg::KIND_TICK, 8'($urandom), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                enqueue_word(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_backlog_empty();
        while (cmd_backlog.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        words_queued       = 0;
        send_idle_pct      = 25;
        recv_idle_pct      = 82;

        // tick with timer stopped, ignored stop, unknown request
        enqueue_word(pcvts_pkg::KIND_TICK, 8'd0, 1'b0);
        enqueue_word(pcvts_pkg::KIND_STOP, 8'd0, 1'b1);
        enqueue_word(KIND_NOP, 8'hff, 1'b1);
        // track zero from idle, then requests while selecting
        enqueue_word(pcvts_pkg::KIND_PLAY, 8'd0, 1'b1);
        enqueue_word(pcvts_pkg::KIND_PLAY, 8'd0, 1'b0);
        enqueue_word(pcvts_pkg::KIND_PLAY, 8'hff, 1'b0);
        enqueue_word(pcvts_pkg::KIND_PLAY, 8'd1, 1'b1);
        enqueue_ticks(6, 50);
        // done phase waits for busy, then pops the next track
        enqueue_word(pcvts_pkg::KIND_TICK, 8'd0, 1'b0);
        enqueue_word(pcvts_pkg::KIND_TICK, 8'hff, 1'b1);
        // stop in the middle of a long train clears the queue
        enqueue_word(pcvts_pkg::KIND_STOP, 8'h55, 1'b0);
        enqueue_ticks(4, 0);
        enqueue_word(pcvts_pkg::KIND_TICK, 8'd0, 1'b1);
        // stop from idle with the chip not ready
        enqueue_word(pcvts_pkg::KIND_STOP, 8'haa, 1'b0);
        enqueue_ticks(4, 100);
        enqueue_word(pcvts_pkg::KIND_TICK, 8'd0, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (words_queued < WORDS_PER_PASS)
            random_episode();
        wait_backlog_empty();

        send_idle_pct = 82;
        recv_idle_pct = 25;
        while (words_queued < 2 * WORDS_PER_PASS)
            random_episode();
        wait_backlog_empty();

        // one pulse train long enough to saturate the counter
        send_idle_pct = 0;
        recv_idle_pct = 0;
        go_idle();
        enqueue_word(pcvts_pkg::KIND_PLAY, 8'($urandom_range(253, 255)), 1'b1);
        enqueue_ticks(515, 50);
        enqueue_word(pcvts_pkg::KIND_TICK, 8'd0, 1'b1);
        while (words_queued < 3 * WORDS_PER_PASS + 520)
            random_episode();
        wait_backlog_empty();

        while (cmd_bus.valid || status_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && status_owed.size() == 0)
            $display("pulse_count_voice_track_sequencer_tb: done, clean");
        else
            $display("pulse_count_voice_track_sequencer_tb: done, errors");
        $finish;
    end

endmodule
